>>> sv/http_field_line_parser_defines.svh
// Assertion macros used by the checker file of the HTTP field line parser.
// Depends on nothing; include by bare file name.
`ifndef HTTP_FIELD_LINE_PARSER_DEFINES_SVH
`define HTTP_FIELD_LINE_PARSER_DEFINES_SVH

// Check a property at each rising clock edge, ignored while reset is high.
`define HFLP_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising clock edge, reset cycles included.
`define HFLP_CHECK_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/hflp_pkg.sv
// Package for the HTTP field line parser: codes, byte constants, item types
// and byte class functions. Depends on nothing.
`timescale 1ns / 1ps

package hflp_pkg;

   // Longest whitespace run held inside a value; the 6-bit count caps it at 63.
   localparam int unsigned MAX_WS_RUN = 32;
   localparam int unsigned RUN_CAP    = (MAX_WS_RUN > 63) ? 63 : MAX_WS_RUN;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned TAB_W      = 32;
   localparam logic [CNT_W-1:0] RUN_CAP_CNT = CNT_W'(RUN_CAP);

   // Byte codes
   localparam logic [7:0] VCHAR_LO = 8'h21;
   localparam logic [7:0] VCHAR_HI = 8'h7E;
   localparam logic [7:0] OBS_LO   = 8'h80;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_HTAB  = 8'h09;

   typedef enum logic [2:0] {
      PH_NAME,
      PH_OWS,
      PH_VALUE,
      PH_LF,
      PH_DONE,
      PH_ERR
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NAME_BYTE,
      KIND_NAME_END,
      KIND_VALUE_BYTE,
      KIND_LINE_END,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       out_byte;
      logic [CNT_W-1:0] ws_count;
      logic [TAB_W-1:0] ws_tabs;
      logic             byte_consumed;
   } rsp_item_type;

   // Token character: digits, letters and the listed punctuation.
   function automatic logic is_tchar(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                       8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
                       8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E};
   endfunction

   function automatic logic is_wsp(input logic [7:0] c);
      return (c == CH_SP) || (c == CH_HTAB);
   endfunction

   // Visible character or obs-text.
   function automatic logic is_vchar(input logic [7:0] c);
      return (c inside {[VCHAR_LO:VCHAR_HI]}) || (c >= OBS_LO);
   endfunction

endpackage

>>> sv/hflp_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on hflp_pkg.
`timescale 1ns / 1ps

interface hflp_req_if
   import hflp_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       restart;

   modport source (output valid, in_byte, restart, input ready);
   modport sink   (input valid, in_byte, restart, output ready);
endinterface

interface hflp_rsp_if
   import hflp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   kind_type         kind;
   logic [7:0]       out_byte;
   logic [CNT_W-1:0] ws_count;
   logic [TAB_W-1:0] ws_tabs;
   logic             byte_consumed;

   modport source (output valid, kind, out_byte, ws_count, ws_tabs, byte_consumed,
                   input ready);
   modport sink   (input valid, kind, out_byte, ws_count, ws_tabs, byte_consumed,
                   output ready);
endinterface

>>> sv/hflp_in_stage.sv
// Input register of the HTTP field line parser: holds one request item until
// the parse stage takes it. Depends on hflp_pkg.
`timescale 1ns / 1ps

module hflp_in_stage
   import hflp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // Accept when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> sv/hflp_core.sv
// Parse stage of the HTTP field line parser: field line state, byte decode
// and the result register. Depends on hflp_pkg.
`timescale 1ns / 1ps

module hflp_core
   import hflp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   phase_type        phase_ff, phase_in;
   logic             name_started_ff, name_started_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [TAB_W-1:0] run_tabs_ff, run_tabs_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;
   logic             emit;

   // State as seen by this item, after an optional restart
   phase_type        ph;
   logic             ns;
   logic [CNT_W-1:0] len;
   logic [TAB_W-1:0] tabs;
   logic [7:0]       b;
   logic             tchar, wsp, vchar, run_full;

   assign b     = item.in_byte;
   assign ph    = item.restart ? PH_NAME : phase_ff;
   assign ns    = item.restart ? 1'b0 : name_started_ff;
   assign len   = item.restart ? '0 : run_len_ff;
   assign tabs  = item.restart ? '0 : run_tabs_ff;
   assign tchar = is_tchar(b);
   assign wsp   = is_wsp(b);
   assign vchar = is_vchar(b);
   assign run_full = (len >= RUN_CAP_CNT);

   // Advance when the result register is free or being emptied
   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   // Next phase
   always_comb begin
      phase_in = ph;
      case (ph)
         PH_NAME: begin
            if (tchar) phase_in = PH_NAME;
            else if (!ns) phase_in = PH_DONE;
            else if (b == CH_COLON) phase_in = PH_OWS;
            else phase_in = PH_ERR;
         end
         PH_OWS, PH_VALUE: begin
            if (ph == PH_OWS && wsp) phase_in = PH_OWS;
            else if (vchar) phase_in = PH_VALUE;
            else if (wsp) phase_in = run_full ? PH_ERR : PH_VALUE;
            else if (b == CH_CR) phase_in = PH_LF;
            else phase_in = PH_ERR;
         end
         PH_LF: begin
            phase_in = (b == CH_LF) ? PH_NAME : PH_ERR;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase
   end

   // Result and run bookkeeping
   always_comb begin
      emit               = 1'b1;
      rsp_in.kind        = KIND_ERROR;
      rsp_in.out_byte    = b;
      rsp_in.ws_count    = '0;
      rsp_in.ws_tabs     = '0;
      name_started_in    = ns;
      run_len_in         = len;
      run_tabs_in        = tabs;
      case (ph)
         PH_NAME: begin
            if (tchar) begin
               name_started_in = 1'b1;
               rsp_in.kind     = KIND_NAME_BYTE;
            end else if (!ns) begin
               rsp_in.kind = KIND_DONE;
            end else if (b == CH_COLON) begin
               name_started_in = 1'b0;
               rsp_in.kind     = KIND_NAME_END;
            end
         end
         PH_OWS, PH_VALUE: begin
            if (ph == PH_OWS && wsp) begin
               emit = 1'b0;
            end else if (vchar) begin
               rsp_in.kind     = KIND_VALUE_BYTE;
               rsp_in.ws_count = len;
               rsp_in.ws_tabs  = tabs;
               run_len_in      = '0;
               run_tabs_in     = '0;
            end else if (wsp) begin
               // Hold the whitespace; positions past the mask read as SP
               if (!run_full) begin
                  emit       = 1'b0;
                  run_len_in = len + CNT_W'(1);
                  if (b == CH_HTAB && !len[CNT_W-1]) begin
                     run_tabs_in = tabs | (TAB_W'(1) << len[CNT_W-2:0]);
                  end
               end
            end else if (b == CH_CR) begin
               // Drop trailing whitespace
               emit        = 1'b0;
               run_len_in  = '0;
               run_tabs_in = '0;
            end
         end
         PH_LF: begin
            if (b == CH_LF) begin
               name_started_in = 1'b0;
               rsp_in.kind     = KIND_LINE_END;
            end
         end
         PH_DONE: begin
            rsp_in.kind = KIND_DONE;
         end
         default: begin
            rsp_in.kind = KIND_ERROR;
         end
      endcase
      rsp_in.byte_consumed = !(rsp_in.kind == KIND_DONE || rsp_in.kind == KIND_ERROR);
   end

   assign rsp_valid_in = take ? emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_NAME;
         name_started_ff <= 1'b0;
         run_len_ff      <= '0;
         run_tabs_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff        <= phase_in;
            name_started_ff <= name_started_in;
            run_len_ff      <= run_len_in;
            run_tabs_ff     <= run_tabs_in;
         end
      end
   end

   // Load the result register only with a result
   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> sv/http_field_line_parser.sv
// HTTP/1.1 header field line parser. One byte of a header section enters per
// item; each item gives zero or one result: a name byte, the name end (colon),
// a value byte with the inner whitespace run that preceded it, the line end
// (LF), section done or error. Leading and trailing whitespace of a value
// produce no results. Done and error are sticky until an item with restart
// set. Throughput is one item per clock while the result port is not stalled;
// the input register captures an item at acceptance and the result register
// captures its decode when the parse stage takes it. req ready follows rsp
// ready within the cycle when both registers are full. Depends on hflp_pkg,
// hflp_if, hflp_in_stage and hflp_core.
`timescale 1ns / 1ps

module http_field_line_parser
   import hflp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   hflp_req_if.sink req_if,
   hflp_rsp_if.source rsp_if
);

   req_item_type req_item, item;
   rsp_item_type rsp_item;
   logic         item_valid, take;

   assign req_item.in_byte = req_if.in_byte;
   assign req_item.restart = req_if.restart;

   hflp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   hflp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_if.kind          = rsp_item.kind;
   assign rsp_if.out_byte      = rsp_item.out_byte;
   assign rsp_if.ws_count      = rsp_item.ws_count;
   assign rsp_if.ws_tabs       = rsp_item.ws_tabs;
   assign rsp_if.byte_consumed = rsp_item.byte_consumed;

endmodule

>>> sv/hflp_checker.sv
// Port-level checks for the HTTP field line parser and their bind to the top.
// Depends on hflp_pkg and http_field_line_parser_defines.svh.
`timescale 1ns / 1ps
`include "http_field_line_parser_defines.svh"

module hflp_checker
   import hflp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kind_type         rsp_kind,
   input logic [7:0]       rsp_out_byte,
   input logic [CNT_W-1:0] rsp_ws_count,
   input logic [TAB_W-1:0] rsp_ws_tabs,
   input logic             rsp_byte_consumed
);

   logic [TAB_W-1:0] tabs_above;
   logic             terminal;
   logic             consumed_ok;
   logic             non_value;
   logic             ws_clear;
   logic             stalled;

   // Tab bits at or beyond the run length must be clear
   assign tabs_above = (rsp_ws_count >= CNT_W'(TAB_W)) ? '0 : (rsp_ws_tabs >> rsp_ws_count);
   assign terminal   = (rsp_kind == KIND_DONE) || (rsp_kind == KIND_ERROR);

   // Decode the conditions the checks look at
   assign consumed_ok = (rsp_byte_consumed == !terminal);
   assign non_value   = rsp_valid && (rsp_kind != KIND_VALUE_BYTE);
   assign ws_clear    = (rsp_ws_count == '0) && (rsp_ws_tabs == '0);
   assign stalled     = rsp_valid && !rsp_ready;

   `HFLP_CHECK_NORST(a_idle_after_reset, clock, reset |=> !rsp_valid, "result after reset")
   `HFLP_CHECK(a_consumed, clock, reset, rsp_valid |-> consumed_ok, "byte_consumed mismatch")
   `HFLP_CHECK(a_ws_only_value, clock, reset, non_value |-> ws_clear, "whitespace on non-value item")
   `HFLP_CHECK(a_tabs_in_run, clock, reset, rsp_valid |-> (tabs_above == '0), "tab bit beyond run")
   `HFLP_CHECK(a_hold, clock, reset, stalled |=> rsp_valid && $stable(rsp_out_byte), "stall broken")

endmodule

bind http_field_line_parser hflp_checker u_hflp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_kind          (rsp_if.kind),
   .rsp_out_byte      (rsp_if.out_byte),
   .rsp_ws_count      (rsp_if.ws_count),
   .rsp_ws_tabs       (rsp_if.ws_tabs),
   .rsp_byte_consumed (rsp_if.byte_consumed)
);
